[sv/sat_pkg.sv]
// shared types, codes and constants of the segment address translator
package sat_pkg;

  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned OWNER_W      = 8;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned CFG_DATA_W   = 5;
  localparam int unsigned REGIONS_DEF  = 16;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FWD   = 2'd1;
  localparam logic [1:0] CMD_REV   = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSLATE_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_SHIFT       = 1'd1;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         slot;
    logic               entry_valid;
    logic [OWNER_W-1:0] entry_owner;
    logic [ADDR_W-1:0]  map_address;
    logic [ADDR_W-1:0]  file_offset;
    logic [ADDR_W-1:0]  seg_vaddr;
    logic [ADDR_W-1:0]  seg_size;
    logic [ADDR_W-1:0]  query_addr;
    logic               filter_enable;
    logic [OWNER_W-1:0] filter_owner;
  } sat_in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] result_addr;
  } sat_out_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [ADDR_W-1:0]  runtime_base;
    logic [ADDR_W-1:0]  linked_base;
    logic [ADDR_W-1:0]  size;
  } sat_entry_t;

  typedef enum logic [1:0] {
    ALU_RTBASE,
    ALU_DIFF,
    ALU_CMP,
    ALU_XLAT
  } sat_alu_op_t;

  typedef enum logic [1:0] {
    RES_PASS,
    RES_MISS,
    RES_HIT
  } sat_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DIFF,
    S_CMP,
    S_XLAT,
    S_MISS,
    S_PASS
  } sat_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       translate_enable;
    logic       slot_ok;
    logic       entry_valid;
    logic       hit;
    logic       out_free;
    logic       in_fire;
  } sat_status_t;

  typedef struct packed {
    logic        in_ready;
    logic        mem_we;
    sat_alu_op_t alu_op;
    logic        diff_load;
    logic        res_load;
    sat_res_t    res_kind;
  } sat_ctrl_t;

endpackage

[sv/segment_address_translator_unit.sv]
// segment address translator: one shared 64-bit adder scans the region table under a sequencer
// a write passes through S_WRITE; a query with translation off goes through S_PASS to the output
// register; a translated query tests each slot in S_READ, then for a valid slot in S_DIFF and S_CMP,
// and ends in S_XLAT or S_MISS, paced by the single adder and the one-port table read
// throughput: one transfer at a time; after a query the next input is taken once its result sits in the
// output register. synchronous reset clears all valid bits at once, translation off, page shift 12
module segment_address_translator_unit #(
  parameter int unsigned REGIONS = sat_pkg::REGIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [sat_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sat_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sat_pkg::sat_in_t                   in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output sat_pkg::sat_out_t                  out_data
);

  localparam int unsigned IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  // configuration registers
  logic                        translate_enable;
  logic [sat_pkg::SHIFT_W-1:0] page_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      translate_enable <= 1'b0;
      page_shift       <= sat_pkg::PAGE_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sat_pkg::CFG_TRANSLATE_ENABLE: translate_enable <= cfg_data[0];
        sat_pkg::CFG_PAGE_SHIFT:       page_shift       <= cfg_data;
        default:                       page_shift       <= page_shift;
      endcase
    end
  end

  // control and status between datapath and sequencer
  sat_pkg::sat_ctrl_t   ctrl;
  sat_pkg::sat_status_t status;
  logic [IDX_W-1:0]     idx;
  logic                 in_fire;

  assign in_ready = ctrl.in_ready;
  assign in_fire  = in_valid && ctrl.in_ready;

  // the accepted item is held for the whole scan
  sat_pkg::sat_in_t item;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
  end

  // region table
  sat_pkg::sat_entry_t wentry;
  sat_pkg::sat_entry_t rentry;
  logic                rvalid;
  logic                slot_ok;
  logic [sat_pkg::ADDR_W-1:0] alu_sum;
  logic                       alu_carry;

  // slots past the table are dropped
  assign slot_ok = ({5'd0, item.slot} < 9'(REGIONS));

  assign wentry.owner        = item.entry_owner;
  assign wentry.runtime_base = alu_sum;
  assign wentry.linked_base  = item.seg_vaddr;
  assign wentry.size         = item.seg_size;

  sat_table #(
    .REGIONS (REGIONS),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .we     (ctrl.mem_we),
    .waddr  (IDX_W'(item.slot)),
    .wvalid (item.entry_valid),
    .wentry (wentry),
    .raddr  (idx),
    .rvalid (rvalid),
    .rentry (rentry)
  );

  // forward queries range-check the linked base, reverse ones the runtime base
  logic [sat_pkg::ADDR_W-1:0] range_base;
  logic [sat_pkg::ADDR_W-1:0] other_base;
  logic [sat_pkg::ADDR_W-1:0] offset_mask;

  assign range_base  = (item.cmd == sat_pkg::CMD_FWD) ? rentry.linked_base : rentry.runtime_base;
  assign other_base  = (item.cmd == sat_pkg::CMD_FWD) ? rentry.runtime_base : rentry.linked_base;
  assign offset_mask = ({{(sat_pkg::ADDR_W-1){1'b0}}, 1'b1} << page_shift) -
                       {{(sat_pkg::ADDR_W-1){1'b0}}, 1'b1};

  // operand selection for the shared adder
  logic [sat_pkg::ADDR_W-1:0] alu_a;
  logic [sat_pkg::ADDR_W-1:0] alu_b;
  logic                       alu_sub;
  logic [sat_pkg::ADDR_W-1:0] diff;
  logic                       diff_ge;

  always_comb begin
    unique case (ctrl.alu_op)
      sat_pkg::ALU_RTBASE: begin
        alu_a   = item.map_address;
        alu_b   = item.file_offset & offset_mask;
        alu_sub = 1'b0;
      end
      sat_pkg::ALU_DIFF: begin
        alu_a   = item.query_addr;
        alu_b   = range_base;
        alu_sub = 1'b1;
      end
      sat_pkg::ALU_CMP: begin
        alu_a   = diff;
        alu_b   = rentry.size;
        alu_sub = 1'b1;
      end
      sat_pkg::ALU_XLAT: begin
        alu_a   = other_base;
        alu_b   = diff;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = item.query_addr;
        alu_b   = range_base;
        alu_sub = 1'b1;
      end
    endcase
  end

  sat_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // offset into the candidate range and whether the address is at or above its base
  always_ff @(posedge clk) begin
    if (ctrl.diff_load) begin
      diff    <= alu_sum;
      diff_ge <= alu_carry;
    end
  end

  // hit: owner filter passes, address >= base, offset below size (no carry on diff - size)
  logic owner_ok;
  logic hit;

  assign owner_ok = !(item.cmd == sat_pkg::CMD_FWD && item.filter_enable) ||
                    (rentry.owner == item.filter_owner);
  assign hit      = owner_ok && diff_ge && !alu_carry;

  // output register, frees as soon as the result transfer completes
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      unique case (ctrl.res_kind)
        sat_pkg::RES_PASS: begin
          out_data.found       <= 1'b1;
          out_data.result_addr <= item.query_addr;
        end
        sat_pkg::RES_HIT: begin
          out_data.found       <= 1'b1;
          out_data.result_addr <= alu_sum;
        end
        sat_pkg::RES_MISS: begin
          out_data.found       <= 1'b0;
          out_data.result_addr <= '0;
        end
        default: begin
          out_data.found       <= 1'b0;
          out_data.result_addr <= '0;
        end
      endcase
    end
  end

  // sequencer
  assign status.cmd              = (ctrl.in_ready) ? in_data.cmd : item.cmd;
  assign status.translate_enable = translate_enable;
  assign status.slot_ok          = slot_ok;
  assign status.entry_valid      = rvalid;
  assign status.hit              = hit;
  assign status.out_free         = out_free;
  assign status.in_fire          = in_fire;

  sat_ctrl #(
    .REGIONS (REGIONS),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .idx    (idx)
  );

endmodule

[sv/sat_alu.sv]
// shared 64-bit add/subtract unit with carry out
module sat_alu (
  input  logic [sat_pkg::ADDR_W-1:0] a,
  input  logic [sat_pkg::ADDR_W-1:0] b,
  input  logic                       sub,
  output logic [sat_pkg::ADDR_W-1:0] sum,
  output logic                       carry
);

  logic [sat_pkg::ADDR_W-1:0] b_op;
  logic [sat_pkg::ADDR_W:0]   total;

  assign b_op  = sub ? ~b : b;
  assign total = {1'b0, a} + {1'b0, b_op} + {{sat_pkg::ADDR_W{1'b0}}, sub};
  assign sum   = total[sat_pkg::ADDR_W-1:0];
  // for a subtract, carry high means a >= b
  assign carry = total[sat_pkg::ADDR_W];

endmodule

[sv/sat_table.sv]
// region table: valid flops plus entry memory with registered read
module sat_table #(
  parameter int unsigned REGIONS = sat_pkg::REGIONS_DEF,
  parameter int unsigned IDX_W   = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  logic                 wvalid,
  input  sat_pkg::sat_entry_t  wentry,
  input  logic [IDX_W-1:0]     raddr,
  output logic                 rvalid,
  output sat_pkg::sat_entry_t  rentry
);

  logic [REGIONS-1:0]  valid;
  sat_pkg::sat_entry_t mem [REGIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= wvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wentry;
    end
    rentry <= mem[raddr];
  end

  assign rvalid = valid[raddr];

endmodule

[sv/sat_ctrl.sv]
// sequencer: slot scan counter and state machine
module sat_ctrl #(
  parameter int unsigned REGIONS = sat_pkg::REGIONS_DEF,
  parameter int unsigned IDX_W   = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sat_pkg::sat_status_t status,
  output sat_pkg::sat_ctrl_t   ctrl,
  output logic [IDX_W-1:0]     idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGIONS - 1);

  sat_pkg::sat_state_t state, state_next;
  logic [IDX_W-1:0]    idx_next;
  logic                last;

  assign last = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sat_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      sat_pkg::S_IDLE: begin
        idx_next = '0;
        if (status.in_fire) begin
          priority if (status.cmd == sat_pkg::CMD_WRITE) begin
            state_next = sat_pkg::S_WRITE;
          end else if (status.cmd == sat_pkg::CMD_NONE) begin
            state_next = sat_pkg::S_IDLE;
          end else if (!status.translate_enable) begin
            state_next = sat_pkg::S_PASS;
          end else begin
            state_next = sat_pkg::S_READ;
          end
        end
      end
      sat_pkg::S_WRITE: state_next = sat_pkg::S_IDLE;
      sat_pkg::S_READ: begin
        priority if (status.entry_valid) begin
          state_next = sat_pkg::S_DIFF;
        end else if (last) begin
          state_next = sat_pkg::S_MISS;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      sat_pkg::S_DIFF: state_next = sat_pkg::S_CMP;
      sat_pkg::S_CMP: begin
        priority if (status.hit) begin
          state_next = sat_pkg::S_XLAT;
        end else if (last) begin
          state_next = sat_pkg::S_MISS;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = sat_pkg::S_READ;
        end
      end
      sat_pkg::S_XLAT, sat_pkg::S_MISS, sat_pkg::S_PASS: begin
        if (status.out_free) begin
          state_next = sat_pkg::S_IDLE;
        end
      end
      default: state_next = sat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.in_ready  = 1'b0;
    ctrl.mem_we    = 1'b0;
    ctrl.alu_op    = sat_pkg::ALU_DIFF;
    ctrl.diff_load = 1'b0;
    ctrl.res_load  = 1'b0;
    ctrl.res_kind  = sat_pkg::RES_MISS;
    unique case (state)
      sat_pkg::S_IDLE:  ctrl.in_ready = 1'b1;
      sat_pkg::S_WRITE: begin
        ctrl.alu_op = sat_pkg::ALU_RTBASE;
        ctrl.mem_we = status.slot_ok;
      end
      sat_pkg::S_READ:  ctrl.alu_op = sat_pkg::ALU_DIFF;
      sat_pkg::S_DIFF: begin
        ctrl.alu_op    = sat_pkg::ALU_DIFF;
        ctrl.diff_load = 1'b1;
      end
      sat_pkg::S_CMP:   ctrl.alu_op = sat_pkg::ALU_CMP;
      sat_pkg::S_XLAT: begin
        ctrl.alu_op   = sat_pkg::ALU_XLAT;
        ctrl.res_load = status.out_free;
        ctrl.res_kind = sat_pkg::RES_HIT;
      end
      sat_pkg::S_MISS: begin
        ctrl.res_load = status.out_free;
        ctrl.res_kind = sat_pkg::RES_MISS;
      end
      sat_pkg::S_PASS: begin
        ctrl.res_load = status.out_free;
        ctrl.res_kind = sat_pkg::RES_PASS;
      end
      default: ctrl.in_ready = 1'b0;
    endcase
  end

endmodule
